// File: rtl/tlg_pkg.sv
// Package: types, codes and constants for the TPM access lifecycle gate.
`default_nettype none

package tlg_pkg;

  // Largest backend context accepted at install, in bytes
  localparam int unsigned CONTEXT_MAX_BYTES = 64;
  // Lifecycle revision placed in the control word
  localparam int unsigned LIFE_REVISION = 1;

  // Control word fields
  localparam logic [31:0] CW_POISON   = 32'h8000_0000;
  localparam logic [31:0] CW_MAGIC    = 32'h2500_0000;
  localparam logic [31:0] CW_REV_MASK = 32'h0000_ff00;

  // Request codes; the unused code falls to the default arm
  typedef enum logic [2:0] {
    OP_INSTALL  = 3'd0,
    OP_ACQUIRE  = 3'd1,
    OP_TRANSMIT = 3'd2,
    OP_END      = 3'd3,
    OP_FAIL     = 3'd4,
    OP_HANDOFF  = 3'd5,
    OP_QUERY    = 3'd6
  } tlg_op_e;

  // Lifecycle states visible between requests
  typedef enum logic [2:0] {
    LS_UNBOUND    = 3'd0,
    LS_AVAILABLE  = 3'd1,
    LS_OWNED      = 3'd3,
    LS_HANDED_OFF = 3'd5,
    LS_FAILED     = 3'd6
  } tlg_life_e;

  // Completion status
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ARG = 2'd1,
    ST_ERR = 2'd2
  } tlg_status_e;

  // One request
  typedef struct packed {
    logic [2:0]  op;
    logic        args_valid;
    logic        backend_complete;
    logic [15:0] context_len;
    logic [63:0] token_gen;
    logic [15:0] request_len;
    logic [15:0] resp_capacity;
    logic        backend_ok;
    logic        release_ok;
    logic [15:0] backend_resp_len;
  } tlg_req_t;

  // One response
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  state_now;
    logic [63:0] token_out;
    logic [15:0] response_len;
    logic        os_access;
    logic [31:0] control_out;
  } tlg_rsp_t;

endpackage

`default_nettype wire

// File: rtl/tlg_if.sv
// Interfaces: request and response channels of the lifecycle gate.
`default_nettype none

interface tlg_req_if import tlg_pkg::*; ();
  logic     valid;
  logic     ready;
  tlg_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlg_rsp_if import tlg_pkg::*; ();
  logic     valid;
  logic     ready;
  tlg_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/tpm_access_lifecycle_gate.sv
// Top level: TPM access lifecycle gate, request register, check logic, response register.
//
// Usage:
//   req_i carries one request per transaction (install, acquire, transmit,
//   end, fail, handoff or query) with the backend outcome flags. rsp_o
//   returns exactly one response per request, in order: status, decoded
//   state, new token, response length, OS access flag and control word.
//   A request is taken into an input register; once the response register is free
//   the checks run against the lifecycle registers, which update, and the response is
//   loaded into the output register. Throughput is one request per cycle while
//   the receiver takes responses, set by the state update (the 64-bit generation
//   increment and compares feeding the lifecycle registers).
//   When the receiver stalls, the response register holds its transaction
//   and one more request can wait in the input register; req_i.ready then
//   drops until the response is taken.
//   Reset (rst_ni low) returns the gate to unbound, clears poison,
//   generation, context length and binding, and empties both registers.
`default_nettype none

module tpm_access_lifecycle_gate import tlg_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tlg_req_if.sink     req_i,
  tlg_rsp_if.source   rsp_o
);

  // Pipeline control
  logic     in_vld_q;
  tlg_req_t in_q;
  logic     out_vld_q;
  tlg_rsp_t out_q;
  logic     out_free;
  logic     proc;

  // Lifecycle registers
  tlg_life_e   life_q, life_d;
  logic        poison_q, poison_d;
  logic [63:0] gen_q, gen_d;
  logic [15:0] ctx_q, ctx_d;
  logic        bound_q, bound_d;
  logic        rev_q, rev_d;

  // Per-request results
  tlg_status_e status;
  logic [63:0] tok_out;
  logic [15:0] resp_len;
  logic        meta_ok;
  logic        tok_ok;
  logic        gen_inc_ovf;
  logic [63:0] gen_inc;
  tlg_rsp_t    rsp_d;
  logic [2:0]  dec_state;
  logic [7:0]  inv_state;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign proc        = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= req_i.data;
    end
  end

  // Shared checks
  assign meta_ok     = rev_q && (ctx_q <= 16'(CONTEXT_MAX_BYTES)) && bound_q;
  assign tok_ok      = (in_q.token_gen != 64'd0) && (in_q.token_gen == gen_q);
  assign gen_inc_ovf = &gen_q;
  assign gen_inc     = gen_q + 64'd1;

  // Next state of the lifecycle registers and the per-request results
  always_comb begin
    life_d   = life_q;
    poison_d = poison_q;
    gen_d    = gen_q;
    ctx_d    = ctx_q;
    bound_d  = bound_q;
    rev_d    = rev_q;
    status   = ST_OK;
    tok_out  = 64'd0;
    resp_len = 16'd0;
    case (in_q.op)
      OP_INSTALL: begin
        if (poison_q || life_q != LS_UNBOUND) begin
          poison_d = 1'b1;
          status   = ST_ERR;
        end else if (!in_q.args_valid || !in_q.backend_complete ||
                     in_q.context_len > 16'(CONTEXT_MAX_BYTES)) begin
          life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
          status = ST_ARG;
        end else begin
          rev_d = 1'b1;
          if (!in_q.backend_ok) begin
            life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
            status = ST_ERR;
          end else begin
            bound_d = 1'b1;
            ctx_d   = in_q.context_len;
            life_d  = LS_AVAILABLE;
          end
        end
      end
      OP_ACQUIRE: begin
        if (!in_q.args_valid) begin
          poison_d = 1'b1;
          status   = ST_ARG;
        end else if (poison_q || life_q != LS_AVAILABLE) begin
          poison_d = 1'b1;
          status   = ST_ERR;
        end else if (!meta_ok || gen_inc_ovf) begin
          life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
          status = ST_ERR;
        end else begin
          gen_d   = gen_inc;
          tok_out = gen_inc;
          life_d  = LS_OWNED;
        end
      end
      OP_TRANSMIT: begin
        if (!in_q.args_valid || in_q.request_len == 16'd0 ||
            in_q.resp_capacity == 16'd0) begin
          poison_d = 1'b1;
          status   = ST_ARG;
        end else if (poison_q || life_q != LS_OWNED) begin
          poison_d = 1'b1;
          status   = ST_ERR;
        end else if (!meta_ok || !tok_ok || !in_q.backend_ok ||
                     in_q.backend_resp_len == 16'd0 ||
                     in_q.backend_resp_len > in_q.resp_capacity) begin
          life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
          status = ST_ERR;
        end else begin
          resp_len = in_q.backend_resp_len;
        end
      end
      OP_END, OP_FAIL: begin
        if (!in_q.args_valid) begin
          poison_d = 1'b1;
          status   = ST_ARG;
        end else if (poison_q || life_q != LS_OWNED) begin
          poison_d = 1'b1;
          status   = ST_ERR;
        end else if (!meta_ok || !tok_ok) begin
          life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
          status = ST_ERR;
        end else if (in_q.op == OP_END) begin
          life_d = LS_AVAILABLE;
        end else begin
          // fail request: seal with success status
          life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
        end
      end
      OP_HANDOFF: begin
        if (poison_q || life_q != LS_AVAILABLE) begin
          poison_d = 1'b1;
          status   = ST_ERR;
        end else if (!meta_ok || !in_q.backend_ok || !in_q.release_ok) begin
          life_d = LS_FAILED; poison_d = 1'b1; bound_d = 1'b0; ctx_d = 16'd0;
          status = ST_ERR;
        end else begin
          bound_d = 1'b0;
          ctx_d   = 16'd0;
          life_d  = LS_HANDED_OFF;
        end
      end
      default: begin
        // query and unused code: no change
      end
    endcase
  end

  // Response fields from the updated state
  always_comb begin
    if (life_d == LS_HANDED_OFF) begin
      dec_state = LS_HANDED_OFF;
    end else if (poison_d) begin
      dec_state = LS_FAILED;
    end else begin
      dec_state = life_d;
    end
    inv_state          = ~{5'd0, life_d};
    rsp_d.status       = status;
    rsp_d.state_now    = dec_state;
    rsp_d.token_out    = tok_out;
    rsp_d.response_len = resp_len;
    rsp_d.os_access    = (dec_state == LS_HANDED_OFF) && rev_d && (ctx_d == 16'd0) &&
                         !bound_d;
    rsp_d.control_out  = 32'd0;
    if (life_d != LS_UNBOUND) begin
      rsp_d.control_out = CW_MAGIC | {8'd0, inv_state, 16'd0} |
                          ((32'(LIFE_REVISION) << 8) & CW_REV_MASK) | {29'd0, life_d};
    end
    if (poison_d) begin
      rsp_d.control_out = rsp_d.control_out | CW_POISON;
    end
  end

  // Lifecycle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q   <= LS_UNBOUND;
      poison_q <= 1'b0;
      gen_q    <= 64'd0;
      ctx_q    <= 16'd0;
      bound_q  <= 1'b0;
      rev_q    <= 1'b0;
    end else if (proc) begin
      life_q   <= life_d;
      poison_q <= poison_d;
      gen_q    <= gen_d;
      ctx_q    <= ctx_d;
      bound_q  <= bound_d;
      rev_q    <= rev_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

// File: rtl/tlg_checker.sv
// Checker: port-level assertions for the lifecycle gate, bound to the top level.
`default_nettype none

module tlg_checker import tlg_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     rsp_valid_i,
  input wire logic     rsp_ready_i,
  input wire tlg_rsp_t rsp_data_i
);

  // Stalled response transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled response changed");

  // Failing requests return no token and no response length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status != ST_OK |->
      rsp_data_i.token_out == 64'd0 && rsp_data_i.response_len == 16'd0)
    else $error("error response carries token or length");

  // OS access only once handed off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.os_access |-> rsp_data_i.state_now == LS_HANDED_OFF)
    else $error("os access outside handed off");

  // Failed decode always shows the poison bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.state_now == LS_FAILED |-> rsp_data_i.control_out[31])
    else $error("failed state without poison bit");

  // A new token means a successful acquire into owned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.token_out != 64'd0 |->
      rsp_data_i.status == ST_OK && rsp_data_i.state_now == LS_OWNED)
    else $error("token issued without ownership");

endmodule

bind tpm_access_lifecycle_gate tlg_checker u_tlg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire

// File: verif/tb_tpm_access_lifecycle_gate.sv
// Testbench: random lifecycle sessions against the TPM access gate, checked by an in-bench predictor.
`timescale 1ns / 100ps

module tb_tpm_access_lifecycle_gate;
  import tlg_pkg::*;

  // Op code with no request behind it; the gate treats it like a query
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int SESSION_ITEMS = 1300;
  localparam int NOISE_ITEMS = 80;
  localparam int LONG_STALL = 200;
  localparam int CYCLE_LIMIT = 200000;

  // Ways the lifecycle is closed at the end of the run
  typedef enum int {
    END_HANDOFF, END_RELEASE_FAIL, END_BAD_RESP, END_BAD_TOKEN,
    END_FAIL_REQ, END_ARG_POISON, END_ZERO_REQ, END_WRONG_STATE
  } ending_e;

  logic clk_i;
  logic rst_ni;

  tlg_req_if req_if ();
  tlg_rsp_if rsp_if ();

  tpm_access_lifecycle_gate dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Gate state as the predictor sees it
  logic [2:0]  gate_life;
  logic        gate_poison;
  logic [63:0] gate_gen;
  logic [15:0] gate_ctx_len;
  logic        gate_bound;
  logic        gate_rev_set;

  tlg_rsp_t verdict_q[$];

  int  n_sent;
  int  n_checked;
  int  n_sessions;
  int  fail_cnt;
  int  cycle_cnt;
  bit  idle_on;
  bit  long_stall_req;
  string ending_name;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses pending", cycle_cnt, verdict_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void gate_seal();
    gate_life    = LS_FAILED;
    gate_poison  = 1'b1;
    gate_bound   = 1'b0;
    gate_ctx_len = '0;
  endfunction

  // Taking a state needs the exact source state and no poison
  function automatic bit gate_claim(logic [2:0] from);
    if (!gate_poison && gate_life == from) return 1'b1;
    gate_poison = 1'b1;
    return 1'b0;
  endfunction

  function automatic tlg_rsp_t gate_step(tlg_req_t r);
    tlg_rsp_t    p;
    logic [1:0]  stat;
    logic [63:0] tok;
    logic [15:0] resp;
    logic [2:0]  st;
    logic [31:0] cw;
    logic        meta_ok;
    logic        tok_ok;
    stat    = ST_OK;
    tok     = '0;
    resp    = '0;
    meta_ok = gate_rev_set && gate_ctx_len <= CONTEXT_MAX_BYTES && gate_bound;
    tok_ok  = r.token_gen != '0 && r.token_gen == gate_gen;
    case (r.op)
      OP_INSTALL: begin
        if (!gate_claim(LS_UNBOUND)) begin
          stat = ST_ERR;
        end else if (!r.args_valid || !r.backend_complete ||
                     r.context_len > CONTEXT_MAX_BYTES) begin
          gate_seal();
          stat = ST_ARG;
        end else begin
          gate_rev_set = 1'b1;
          gate_bound   = 1'b1;
          gate_ctx_len = r.context_len;
          if (!r.backend_ok) begin
            gate_seal();
            stat = ST_ERR;
          end else begin
            gate_life = LS_AVAILABLE;
          end
        end
      end
      OP_ACQUIRE: begin
        if (!r.args_valid) begin
          gate_poison = 1'b1;
          stat = ST_ARG;
        end else if (!gate_claim(LS_AVAILABLE)) begin
          stat = ST_ERR;
        end else if (!meta_ok || gate_gen == '1) begin
          gate_seal();
          stat = ST_ERR;
        end else begin
          gate_gen  = gate_gen + 64'd1;
          tok       = gate_gen;
          gate_life = LS_OWNED;
        end
      end
      OP_TRANSMIT: begin
        if (!r.args_valid || r.request_len == '0 || r.resp_capacity == '0) begin
          gate_poison = 1'b1;
          stat = ST_ARG;
        end else if (!gate_claim(LS_OWNED)) begin
          stat = ST_ERR;
        end else if (!meta_ok || !tok_ok || !r.backend_ok || r.backend_resp_len == '0 ||
                     r.backend_resp_len > r.resp_capacity) begin
          gate_seal();
          stat = ST_ERR;
        end else begin
          resp = r.backend_resp_len;
        end
      end
      OP_END, OP_FAIL: begin
        if (!r.args_valid) begin
          gate_poison = 1'b1;
          stat = ST_ARG;
        end else if (!gate_claim(LS_OWNED)) begin
          stat = ST_ERR;
        end else if (!meta_ok || !tok_ok) begin
          gate_seal();
          stat = ST_ERR;
        end else if (r.op == OP_FAIL) begin
          gate_seal();
        end else begin
          gate_life = LS_AVAILABLE;
        end
      end
      OP_HANDOFF: begin
        if (!gate_claim(LS_AVAILABLE)) begin
          stat = ST_ERR;
        end else if (!meta_ok || !r.backend_ok || !r.release_ok) begin
          gate_seal();
          stat = ST_ERR;
        end else begin
          gate_bound   = 1'b0;
          gate_ctx_len = '0;
          gate_life    = LS_HANDED_OFF;
        end
      end
      default: ;
    endcase

    // Handed off wins over poison in the decoded state
    if (gate_life == LS_HANDED_OFF) st = LS_HANDED_OFF;
    else if (gate_poison)           st = LS_FAILED;
    else                            st = gate_life;

    cw = '0;
    if (gate_life != LS_UNBOUND)
      cw = CW_MAGIC | {8'h00, ~{5'b0, gate_life}, 16'h0000} |
           ((32'(LIFE_REVISION) << 8) & CW_REV_MASK) | {29'h0, gate_life};
    if (gate_poison) cw = cw | CW_POISON;

    p.status       = stat;
    p.state_now    = st;
    p.token_out    = tok;
    p.response_len = resp;
    p.os_access    = (st == LS_HANDED_OFF) && gate_rev_set && gate_ctx_len == '0 && !gate_bound;
    p.control_out  = cw;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  function automatic void report_diff(string what, logic [63:0] want, logic [63:0] got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("Mismatch on %s at response %0d: expected %h, got %h", what, n_checked, want, got);
  endfunction

  // Receiver: random hold-offs per transaction, one long stretch on request
  initial begin : rsp_sink
    int gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (long_stall_req) begin
        gap = gap + LONG_STALL;
        long_stall_req = 1'b0;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  // Each response transaction against the oldest prediction
  always @(posedge clk_i) begin : rsp_check
    tlg_rsp_t got;
    tlg_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (verdict_q.size() == 0) begin
        report_diff("unexpected response (control word)", '0, 64'(got.control_out));
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report_diff("status", 64'(want.status), 64'(got.status));
        if (got.state_now !== want.state_now)
          report_diff("state_now", 64'(want.state_now), 64'(got.state_now));
        if (got.token_out !== want.token_out)
          report_diff("token_out", want.token_out, got.token_out);
        if (got.response_len !== want.response_len)
          report_diff("response_len", 64'(want.response_len), 64'(got.response_len));
        if (got.os_access !== want.os_access)
          report_diff("os_access", 64'(want.os_access), 64'(got.os_access));
        if (got.control_out !== want.control_out)
          report_diff("control_out", 64'(want.control_out), 64'(got.control_out));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // One request transaction; prediction happens at acceptance
  task automatic issue_request(input tlg_req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.data  <= r;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    verdict_q.push_back(gate_step(r));
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic tlg_req_t noise_req();
    tlg_req_t r;
    r.op               = 3'($urandom_range(0, 7));
    r.args_valid       = 1'($urandom);
    r.backend_complete = 1'($urandom);
    r.context_len      = 16'($urandom);
    r.token_gen        = {$urandom, $urandom};
    r.request_len      = 16'($urandom);
    r.resp_capacity    = 16'($urandom);
    r.backend_ok       = 1'($urandom);
    r.release_ok       = 1'($urandom);
    r.backend_resp_len = 16'($urandom);
    return r;
  endfunction

  // A request that passes every check from the right state
  function automatic tlg_req_t good_req(logic [2:0] op);
    tlg_req_t r;
    r = noise_req();
    r.op               = op;
    r.args_valid       = 1'b1;
    r.backend_complete = 1'b1;
    r.backend_ok       = 1'b1;
    r.release_ok       = 1'b1;
    r.token_gen        = gate_gen;
    r.context_len      = 16'($urandom_range(0, CONTEXT_MAX_BYTES));
    r.request_len      = 16'($urandom_range(1, 65535));
    r.resp_capacity    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 16))
                                                     : 16'($urandom_range(1, 65535));
    r.backend_resp_len = 16'($urandom_range(1, r.resp_capacity));
    return r;
  endfunction

  // Acquire, a few transfers with queries mixed in, release
  task automatic run_session(input int n_xfer);
    tlg_req_t r;
    issue_request(good_req(OP_ACQUIRE));
    repeat (n_xfer) begin
      if ($urandom_range(0, 4) == 0) begin
        r = noise_req();
        r.op = ($urandom_range(0, 1) == 0) ? OP_QUERY : OP_UNUSED;
      end else begin
        r = good_req(OP_TRANSMIT);
      end
      issue_request(r);
    end
    issue_request(good_req(OP_END));
    n_sessions++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes along the normal path: install, two sessions, no faults
  task automatic test_directed_lifecycle();
    tlg_req_t r;
    idle_on = 1'b0;
    r = '0; r.op = OP_QUERY;  issue_request(r);
    r = '1; r.op = OP_UNUSED; issue_request(r);
    r = '1; r.op = OP_QUERY;  issue_request(r);
    // install with the largest context allowed
    r = '0;
    r.op = OP_INSTALL; r.args_valid = 1'b1; r.backend_complete = 1'b1;
    r.context_len = 16'(CONTEXT_MAX_BYTES); r.backend_ok = 1'b1;
    issue_request(r);
    r = '1; r.op = OP_QUERY;   issue_request(r);
    r = '1; r.op = OP_ACQUIRE; issue_request(r);
    // largest transfer
    r = '1; r.op = OP_TRANSMIT; r.token_gen = gate_gen; issue_request(r);
    // smallest transfer
    r = '0;
    r.op = OP_TRANSMIT; r.args_valid = 1'b1; r.token_gen = gate_gen;
    r.request_len = 16'd1; r.resp_capacity = 16'd1; r.backend_resp_len = 16'd1;
    r.backend_ok = 1'b1;
    issue_request(r);
    // response exactly fills the buffer
    r.request_len = 16'h8000; r.resp_capacity = 16'h8000; r.backend_resp_len = 16'h8000;
    issue_request(r);
    r = '0; r.op = OP_UNUSED; issue_request(r);
    r = '0; r.op = OP_END; r.args_valid = 1'b1; r.token_gen = gate_gen; issue_request(r);
    r = '0; r.op = OP_ACQUIRE; r.args_valid = 1'b1; issue_request(r);
    r = '1; r.op = OP_END; r.token_gen = gate_gen; issue_request(r);
  endtask

  // Well-formed sessions with random content and random idling
  task automatic test_random_sessions();
    while (n_sent < SESSION_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_session($urandom_range(0, 8));
    end
  endtask

  // Receiver stalls a long time while requests keep coming
  task automatic test_stall_fill();
    idle_on = 1'b0;
    long_stall_req = 1'b1;
    run_session(20);
  endtask

  // Close the lifecycle one way, then hammer the closed gate
  task automatic test_sealing_fault();
    tlg_req_t r;
    ending_e  how;
    how = ending_e'($urandom_range(0, 7));
    idle_on = 1'b1;
    case (how)
      END_HANDOFF: begin
        ending_name = "a clean handoff and a late acquire";
        issue_request(good_req(OP_HANDOFF));
        issue_request(good_req(OP_ACQUIRE));
      end
      END_RELEASE_FAIL: begin
        ending_name = "a failed release at handoff";
        r = good_req(OP_HANDOFF);
        r.release_ok = 1'b0;
        issue_request(r);
      end
      END_WRONG_STATE: begin
        ending_name = "a second install";
        issue_request(good_req(OP_INSTALL));
      end
      default: begin
        issue_request(good_req(OP_ACQUIRE));
        case (how)
          END_BAD_RESP: begin
            ending_name = "a bad backend response";
            r = good_req(OP_TRANSMIT);
            case ($urandom_range(0, 2))
              0: begin
                r.resp_capacity = 16'($urandom_range(1, 65534));
                r.backend_resp_len = r.resp_capacity + 16'd1;
              end
              1: r.backend_resp_len = '0;
              default: r.backend_ok = 1'b0;
            endcase
          end
          END_BAD_TOKEN: begin
            ending_name = "a stale token";
            r = good_req(($urandom_range(0, 1) == 0) ? OP_TRANSMIT : OP_END);
            r.token_gen = ($urandom_range(0, 1) == 0) ? 64'd0 : gate_gen + 64'd1;
          end
          END_FAIL_REQ: begin
            ending_name = "a fail request";
            r = good_req(OP_FAIL);
          end
          END_ARG_POISON: begin
            ending_name = "an argument error while owned";
            r = good_req(OP_END);
            r.args_valid = 1'b0;
          end
          default: begin
            ending_name = "a zero-length transfer";
            r = good_req(OP_TRANSMIT);
            if ($urandom_range(0, 1) == 0) r.request_len = '0;
            else r.resp_capacity = '0;
          end
        endcase
        issue_request(r);
      end
    endcase
    repeat (NOISE_ITEMS) issue_request(noise_req());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    idle_on        = 1'b0;
    long_stall_req = 1'b0;
    n_sent         = 0;
    n_checked      = 0;
    n_sessions     = 0;
    fail_cnt       = 0;
    cycle_cnt      = 0;
    gate_life      = LS_UNBOUND;
    gate_poison    = 1'b0;
    gate_gen       = '0;
    gate_ctx_len   = '0;
    gate_bound     = 1'b0;
    gate_rev_set   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_lifecycle();
    test_random_sessions();
    test_stall_fill();
    test_sealing_fault();

    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests in %0d owned sessions, checked %0d responses, %0d mismatches.",
             n_sent, n_sessions, n_checked, fail_cnt);
    $display("Lifecycle closed by %s, then %0d random requests on the closed gate.",
             ending_name, NOISE_ITEMS);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tlg_pkg.sv
rtl/tlg_if.sv
rtl/tpm_access_lifecycle_gate.sv
rtl/tlg_checker.sv
verif/tb_tpm_access_lifecycle_gate.sv
